// ----- design/hdlf_pkg.sv -----
// Shared types, constants and helpers for the hex dump line formatter.
// Used by hdlf_ctrl, hdlf_datapath and hex_dump_line_formatter; no dependencies.
package hdlf_pkg;

  // Line geometry.
  localparam int unsigned BytesPerLine = 16;
  localparam int unsigned PosW         = $clog2(BytesPerLine);
  localparam int unsigned AddrW        = 32;
  localparam int unsigned AddrDigits   = AddrW / 4;
  localparam int unsigned DigitW       = $clog2(AddrDigits);

  // Configuration port.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GROUP_SIZE_LOG = 1'b0,
    CFG_ISO_CHARSET    = 1'b1
  } cfg_reg_e;

  // Characters used by the formatter.
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChColon   = 8'h3a;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChDot     = 8'h2e;
  localparam logic [7:0] ChDel     = 8'h7f;
  localparam logic [7:0] ChIsoLow  = 8'ha0;

  // Input item kinds.
  localparam logic KindData = 1'b0;
  localparam logic KindEos  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } hdlf_in_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } hdlf_out_t;

  // Source of the character placed in the output register.
  typedef enum logic [2:0] {
    SEL_ADDR,
    SEL_COLON,
    SEL_SPACE,
    SEL_HI,
    SEL_LO,
    SEL_TEXT,
    SEL_NL
  } char_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDR,
    ST_COLON,
    ST_ADDR_SP,
    ST_HI,
    ST_LO,
    ST_GSEP,
    ST_PAD_A,
    ST_PAD_B,
    ST_PAD_SEP,
    ST_TXT_SP,
    ST_TEXT,
    ST_NL
  } hdlf_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      emit;
    char_sel_e sel;
    logic      last;
    logic      idx_clr;
    logic      idx_load_pos;
    logic      idx_inc;
    logic      pos_inc;
    logic      pos_clr;
    logic      addr_inc;
    logic      addr_clr;
  } hdlf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_kind;
    logic kind;
    logic pos_zero;
    logic pos_last;
    logic ge_pos;
    logic ge_idx;
    logic idx_addr_last;
    logic idx_last;
    logic text_last;
    logic out_free;
  } hdlf_sts_t;

  // Lowercase hex digit for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'h0, nib};
    end else begin
      ch = 8'h57 + {4'h0, nib};
    end
    return ch;
  endfunction

  // True when byte slot i closes a group of 2^log2_size bytes.
  function automatic logic group_end(input logic [PosW-1:0] i, input logic [1:0] log2_size);
    logic [PosW-1:0] mask;
    mask = PosW'((4'd1 << log2_size) - 4'd1);
    return (i & mask) == mask;
  endfunction

endpackage

// ----- design/hex_dump_line_formatter.sv -----
// Top level of the hex dump line formatter: controller plus datapath.
// Depends on hdlf_pkg, hdlf_ctrl and hdlf_datapath.
//
// Usage: items arrive on the in channel (valid/ready, hdlf_in_t): a data
// byte or an end-of-stream marker. Each item yields zero or more characters
// on the out channel (valid/ready, hdlf_out_t), one per transfer; the final
// character of an item carries last_char. Registers are written through the
// cfg channel (index, data), which is always ready; write them while idle.
// The input item is latched at its transfer as the state leaves idle; the
// first character is then written to the output register. The sequencer
// produces one character per cycle into a single output register unless
// the receiver stalls. A data byte takes an idle slot, two digits and an
// optional separator, plus the address at the start of a line and the text
// column at its end. End of stream emits the padding and text characters.
// One item is processed at a time; in_ready_o is high only between items.
// Reset clears position and address to zero and restores the register
// defaults. When the receiver stalls, the pending character holds and the
// sequencer waits on it; no character is dropped.
module hex_dump_line_formatter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hdlf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hdlf_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  hdlf_pkg::hdlf_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output hdlf_pkg::hdlf_out_t           out_data_o
);
  import hdlf_pkg::*;

  hdlf_cmd_t cmd;
  hdlf_sts_t sts;

  assign cfg_ready_o = 1'b1;

  hdlf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hdlf_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // The sequencer never overwrites a character that is still waiting.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || out_ready_i))
    else $error("character emitted over a pending output");

  // An item is loaded only on an input transfer.
  a_load_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (in_valid_i && in_ready_o))
    else $error("item loaded without an input transfer");

  // After the final character of an item the block is ready for the next.
  a_last_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && cmd.last) |=> in_ready_o)
    else $error("not ready after the final character of an item");

  // A loaded data byte leaves the block not ready in the following cycle, so it produces at least one character.
  a_data_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load && (in_data_i.kind == KindData)) |=> !in_ready_o)
    else $error("data byte returned to idle without output");

endmodule

// ----- design/hdlf_ctrl.sv -----
// Sequencing state machine of the hex dump line formatter.
// Depends on hdlf_pkg; drives hdlf_datapath through hdlf_cmd_t.
module hdlf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hdlf_pkg::hdlf_sts_t sts_i,
  output hdlf_pkg::hdlf_cmd_t cmd_o
);
  import hdlf_pkg::*;

  hdlf_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands. Every state but idle emits one character per
  // transfer slot of the output register.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.sel  = SEL_SPACE;
    in_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_kind == KindData) begin
            if (sts_i.pos_zero) begin
              cmd_o.idx_clr = 1'b1;
              state_d       = ST_ADDR;
            end else begin
              state_d = ST_HI;
            end
          end else if (!sts_i.pos_zero) begin
            cmd_o.idx_load_pos = 1'b1;
            state_d            = ST_PAD_A;
          end else begin
            cmd_o.pos_clr  = 1'b1;
            cmd_o.addr_clr = 1'b1;
          end
        end
      end

      ST_ADDR: begin
        cmd_o.sel = SEL_ADDR;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.idx_addr_last) begin
            state_d = ST_COLON;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end

      ST_COLON: begin
        cmd_o.sel = SEL_COLON;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_ADDR_SP;
        end
      end

      ST_ADDR_SP: begin
        cmd_o.sel = SEL_SPACE;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_HI;
        end
      end

      ST_HI: begin
        cmd_o.sel = SEL_HI;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_LO;
        end
      end

      // The low digit closes the item unless a group separator follows.
      ST_LO: begin
        cmd_o.sel  = SEL_LO;
        cmd_o.last = !sts_i.ge_pos;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.ge_pos) begin
            state_d = ST_GSEP;
          end else begin
            cmd_o.pos_inc = 1'b1;
            state_d       = ST_IDLE;
          end
        end
      end

      // On the last slot of the line the position wraps to zero and the
      // text column follows.
      ST_GSEP: begin
        cmd_o.sel  = SEL_SPACE;
        cmd_o.last = !sts_i.pos_last;
        if (sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.pos_inc = 1'b1;
          if (sts_i.pos_last) begin
            state_d = ST_TXT_SP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_PAD_A: begin
        cmd_o.sel = SEL_SPACE;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_PAD_B;
        end
      end

      ST_PAD_B: begin
        cmd_o.sel = SEL_SPACE;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.ge_idx) begin
            state_d = ST_PAD_SEP;
          end else if (sts_i.idx_last) begin
            state_d = ST_TXT_SP;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_PAD_A;
          end
        end
      end

      ST_PAD_SEP: begin
        cmd_o.sel = SEL_SPACE;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.idx_last) begin
            state_d = ST_TXT_SP;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_PAD_A;
          end
        end
      end

      ST_TXT_SP: begin
        cmd_o.sel = SEL_SPACE;
        if (sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_TEXT;
        end
      end

      ST_TEXT: begin
        cmd_o.sel = SEL_TEXT;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.text_last) begin
            state_d = ST_NL;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end

      // A full line moves the address on; end of stream restarts at zero.
      ST_NL: begin
        cmd_o.sel  = SEL_NL;
        cmd_o.last = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.kind == KindData) begin
            cmd_o.addr_inc = 1'b1;
          end else begin
            cmd_o.pos_clr  = 1'b1;
            cmd_o.addr_clr = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/hdlf_datapath.sv -----
// Datapath of the hex dump line formatter: configuration, line state,
// text column store and output register. Depends on hdlf_pkg.
module hdlf_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [hdlf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hdlf_pkg::CfgDataW-1:0] cfg_data_i,
  input  hdlf_pkg::hdlf_in_t         in_data_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output hdlf_pkg::hdlf_out_t        out_data_o,
  input  hdlf_pkg::hdlf_cmd_t        cmd_i,
  output hdlf_pkg::hdlf_sts_t        sts_o
);
  import hdlf_pkg::*;

  logic [1:0]        group_log_q;
  logic              iso_q;
  logic [PosW-1:0]   pos_q;
  logic [AddrW-1:0]  addr_q;
  logic [PosW-1:0]   idx_q;
  logic              kind_q;
  logic [7:0]        byte_q;
  logic [7:0]        text_q [BytesPerLine];
  logic [7:0]        char_q;
  logic              last_q;
  logic              out_valid_q;

  logic              shown;
  logic [7:0]        text_char;
  logic [4:0]        nib_lsb;
  logic [7:0]        char_d;

  // Configuration registers; indexes outside the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_log_q <= 2'd1;
      iso_q       <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GROUP_SIZE_LOG: group_log_q <= cfg_data_i[1:0];
        CFG_ISO_CHARSET:    iso_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Line position and address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      addr_q <= '0;
    end else begin
      if (cmd_i.pos_clr) begin
        pos_q <= '0;
      end else if (cmd_i.pos_inc) begin
        pos_q <= pos_q + PosW'(1);
      end
      if (cmd_i.addr_clr) begin
        addr_q <= '0;
      end else if (cmd_i.addr_inc) begin
        addr_q <= addr_q + AddrW'(BytesPerLine);
      end
    end
  end

  // Loop counter shared by the address digits, padding and text column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_load_pos) begin
      idx_q <= pos_q;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + PosW'(1);
    end
  end

  // Printable test for the text column.
  always_comb begin
    shown = ((in_data_i.data_byte >= ChSpace) && (in_data_i.data_byte < ChDel)) ||
            (iso_q && (in_data_i.data_byte >= ChIsoLow));
    text_char = shown ? in_data_i.data_byte : ChDot;
  end

  // Latched item and text column entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_data_i.kind;
      byte_q <= in_data_i.data_byte;
      if (in_data_i.kind == KindData) begin
        text_q[pos_q] <= text_char;
      end
    end
  end

  // Character select.
  assign nib_lsb = {~idx_q[DigitW-1:0], 2'b00};

  always_comb begin
    case (cmd_i.sel)
      SEL_ADDR:  char_d = hex_char(addr_q[nib_lsb +: 4]);
      SEL_COLON: char_d = ChColon;
      SEL_SPACE: char_d = ChSpace;
      SEL_HI:    char_d = hex_char(byte_q[7:4]);
      SEL_LO:    char_d = hex_char(byte_q[3:0]);
      SEL_TEXT:  char_d = text_q[idx_q];
      SEL_NL:    char_d = ChNewline;
      default:   char_d = ChSpace;
    endcase
  end

  // Output register: holds one character until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      char_q <= char_d;
      last_q <= cmd_i.last;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_data_o.text_char = char_q;
  assign out_data_o.last_char = last_q;

  // Status back to the controller.
  always_comb begin
    sts_o.in_kind       = in_data_i.kind;
    sts_o.kind          = kind_q;
    sts_o.pos_zero      = (pos_q == '0);
    sts_o.pos_last      = (pos_q == PosW'(BytesPerLine - 1));
    sts_o.ge_pos        = group_end(pos_q, group_log_q);
    sts_o.ge_idx        = group_end(idx_q, group_log_q);
    sts_o.idx_addr_last = (idx_q == PosW'(AddrDigits - 1));
    sts_o.idx_last      = (idx_q == PosW'(BytesPerLine - 1));
    sts_o.text_last     = ((idx_q + PosW'(1)) == pos_q);
    sts_o.out_free      = !out_valid_q || out_ready_i;
  end

endmodule
